/* rtl/mbbe_pkg.sv */
package mbbe_pkg;

    localparam int CFG_W     = 12;
    localparam int COLOR_W   = 24;
    localparam int INDEX_W   = 22;
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR     = 3'd7;

    localparam logic [CFG_W-1:0] RST_LINE_STRIDE    = 12'd640;
    localparam logic [CFG_W-1:0] RST_VISIBLE_HEIGHT = 12'd480;
    localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH   = 12'd640;

    typedef struct packed {
        logic [CFG_W-1:0]   line_stride;
        logic [CFG_W-1:0]   visible_height;
        logic [CFG_W-1:0]   screen_width;
        logic [CFG_W-1:0]   origin_x;
        logic [CFG_W-1:0]   origin_y;
        logic [CFG_W-1:0]   bitmap_width;
        logic [CFG_W-1:0]   bitmap_height;
        logic [COLOR_W-1:0] fore_color;
    } cfg_t;

endpackage

/* rtl/mbbe_queue.sv */
module mbbe_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/mbbe_front.sv */
module mbbe_front #(
    parameter int WORD_BITS = 32,
    parameter int MAX_DIM   = 2048,
    parameter int WIR_W     = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbbe_pkg::cfg_t            cfg,
    input  logic                      push,
    input  logic [WORD_BITS-1:0]      bitmap_word,
    input  logic                      q_full,
    output logic                      q_push,
    output logic [WORD_BITS-1:0]      q_word,
    output logic [mbbe_pkg::CFG_W-1:0] q_py,
    output logic [WIR_W-1:0]          q_wir
);

    localparam int CW     = mbbe_pkg::CFG_W;
    localparam int LOG_WB = $clog2(WORD_BITS);
    localparam int ROW_W  = $clog2(MAX_DIM);
    localparam int WPR_W  = WIR_W + 1;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [WIR_W-1:0] wir_reg;
    logic [WIR_W-1:0] wir_next;
    logic             accept;
    logic             dims_ok;
    logic             row_ok;
    logic [CW:0]      bw_up;
    logic [WPR_W-1:0] wpr;
    logic [WPR_W-1:0] wir_inc;
    logic [CW:0]      row_inc;
    logic [CW+1:0]    py;

    assign accept  = push && !q_full;
    assign dims_ok = (cfg.bitmap_width != '0) && (cfg.bitmap_height != '0);
    assign bw_up   = {1'b0, cfg.bitmap_width} + (CW + 1)'(WORD_BITS - 1);
    assign wpr     = WPR_W'(bw_up >> LOG_WB);
    assign wir_inc = {1'b0, wir_reg} + 1'b1;
    assign row_inc = (CW + 1)'(row_reg) + 1'b1;
    assign py      = {{2{cfg.origin_y[CW-1]}}, cfg.origin_y} + (CW + 2)'(row_reg);
    assign row_ok  = !py[CW+1] && (py[CW:0] < {1'b0, cfg.visible_height});

    assign q_push = accept && dims_ok && row_ok;
    assign q_word = bitmap_word;
    assign q_py   = py[CW-1:0];
    assign q_wir  = wir_reg;

    always_comb
    begin
        row_next = row_reg;
        wir_next = wir_reg;
        if (accept)
        begin
            if (!dims_ok)
            begin
                row_next = '0;
                wir_next = '0;
            end
            else if (wir_inc >= wpr)
            begin
                wir_next = '0;
                row_next = (row_inc >= {1'b0, cfg.bitmap_height}) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                wir_next = wir_inc[WIR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            wir_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            wir_reg <= wir_next;
        end
    end

endmodule

/* rtl/mbbe_back.sv */
module mbbe_back #(
    parameter int WORD_BITS = 32,
    parameter int WIR_W     = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mbbe_pkg::cfg_t               cfg,
    input  logic                         q_valid,
    input  logic [WORD_BITS-1:0]         q_word,
    input  logic [mbbe_pkg::CFG_W-1:0]   q_py,
    input  logic [WIR_W-1:0]             q_wir,
    output logic                         q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [mbbe_pkg::INDEX_W-1:0] pixel_index,
    output logic [mbbe_pkg::VALUE_W-1:0] pixel_value,
    output logic                         last_of_word
);

    localparam int CW     = mbbe_pkg::CFG_W;
    localparam int IW     = mbbe_pkg::INDEX_W;
    localparam int LOG_WB = $clog2(WORD_BITS);
    localparam int COL_W  = CW + 1;
    localparam int PX_W   = CW + 3;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [PX_W-1:0]      px_reg;
    logic [PX_W-1:0]      px_next;
    logic [LOG_WB-1:0]    cnt_reg;
    logic [LOG_WB-1:0]    cnt_next;
    logic [IW-1:0]        base_reg;
    logic [IW-1:0]        base_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [IW-1:0]        pend_index_reg;
    logic [IW-1:0]        pend_index_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [IW-1:0]        out_index_reg;
    logic [IW-1:0]        out_index_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic                 out_free;
    logic                 hit;
    logic                 stall;
    logic                 done;
    logic [WORD_BITS-1:0] word_rest;
    logic [COL_W-1:0]     col0;
    logic [2*CW-1:0]      prod;
    logic [IW-1:0]        new_index;

    assign out_free     = !out_valid_reg || pop;
    assign empty        = !out_valid_reg;
    assign pixel_index  = out_index_reg;
    assign last_of_word = out_last_reg;
    assign pixel_value  = {mbbe_pkg::ALPHA_OPAQUE, cfg.fore_color};

    assign col0      = COL_W'({q_wir, {LOG_WB{1'b0}}});
    assign prod      = q_py * cfg.line_stride;
    assign hit       = word_reg[WORD_BITS-1]
                       && (col_reg < {1'b0, cfg.bitmap_width})
                       && !px_reg[PX_W-1]
                       && (px_reg[PX_W-2:0] < (PX_W - 1)'(cfg.screen_width));
    assign new_index = base_reg + IW'(px_reg[PX_W-2:0]);
    assign word_rest = word_reg << 1;
    assign done      = (cnt_reg == LOG_WB'(WORD_BITS - 1)) || (word_rest == '0);
    assign stall     = hit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        col_next        = col_reg;
        px_next         = px_reg;
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    word_next  = q_word;
                    col_next   = col0;
                    px_next    = {{3{cfg.origin_x[CW-1]}}, cfg.origin_x} + PX_W'(col0);
                    cnt_next   = '0;
                    base_next  = prod[IW-1:0];
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_index_next = pend_index_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_index_next = new_index;
                    end
                    word_next = word_rest;
                    col_next  = col_reg + 1'b1;
                    px_next   = px_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (done)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = pend_index_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        col_reg        <= col_next;
        px_reg         <= px_next;
        cnt_reg        <= cnt_next;
        base_reg       <= base_next;
        pend_index_reg <= pend_index_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
    end

endmodule

/* rtl/mono_bitmap_blit_expander.sv */
// Channel   Handshake        Word
// -------   ---------------  ----------------------------------------------
// input     push / full      bitmap_word
// result    empty / pop      pixel_index, pixel_value, last_of_word
// config    cfg_we           cfg_index, cfg_data
//
// A word whose row is visible goes through the pixel scanner (load, one bit per
// cycle unless the result output stalls, final flush); the scan ends early once no
// set bits remain. A word on a clipped row or an empty bitmap never enters the queue.
// Reset clears the row and word counters and loads the register defaults.
// Pop held low stalls the scanner; the two-word queue then fills and raises full.
module mono_bitmap_blit_expander #(
    parameter int WORD_BITS = 32,
    parameter int MAX_DIM   = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [WORD_BITS-1:0]           bitmap_word,
    output logic                           empty,
    input  logic                           pop,
    output logic [mbbe_pkg::INDEX_W-1:0]   pixel_index,
    output logic [mbbe_pkg::VALUE_W-1:0]   pixel_value,
    output logic                           last_of_word,
    input  logic                           cfg_we,
    input  logic [mbbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbbe_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int CW      = mbbe_pkg::CFG_W;
    localparam int WPR_MAX = (MAX_DIM + WORD_BITS - 1) / WORD_BITS;
    localparam int WIR_W   = (WPR_MAX > 1) ? $clog2(WPR_MAX) : 1;
    localparam int Q_W     = WORD_BITS + CW + WIR_W;
    localparam logic [CW:0] DIM_CAP = (CW + 1)'(MAX_DIM);

    mbbe_pkg::cfg_t cfg_reg;

    logic                 f_push;
    logic [WORD_BITS-1:0] f_word;
    logic [CW-1:0]        f_py;
    logic [WIR_W-1:0]     f_wir;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [Q_W-1:0]       q_rdata;
    logic [CW-1:0]        dim_val;

    assign full    = q_full;
    assign dim_val = ({1'b0, cfg_data[CW-1:0]} > DIM_CAP) ? DIM_CAP[CW-1:0] : cfg_data[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_stride    <= mbbe_pkg::RST_LINE_STRIDE;
            cfg_reg.visible_height <= mbbe_pkg::RST_VISIBLE_HEIGHT;
            cfg_reg.screen_width   <= mbbe_pkg::RST_SCREEN_WIDTH;
            cfg_reg.origin_x       <= '0;
            cfg_reg.origin_y       <= '0;
            cfg_reg.bitmap_width   <= '0;
            cfg_reg.bitmap_height  <= '0;
            cfg_reg.fore_color     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbbe_pkg::REG_LINE_STRIDE:    cfg_reg.line_stride    <= cfg_data[CW-1:0];
                mbbe_pkg::REG_VISIBLE_HEIGHT: cfg_reg.visible_height <= cfg_data[CW-1:0];
                mbbe_pkg::REG_SCREEN_WIDTH:   cfg_reg.screen_width   <= cfg_data[CW-1:0];
                mbbe_pkg::REG_ORIGIN_X:       cfg_reg.origin_x       <= cfg_data[CW-1:0];
                mbbe_pkg::REG_ORIGIN_Y:       cfg_reg.origin_y       <= cfg_data[CW-1:0];
                mbbe_pkg::REG_BITMAP_WIDTH:   cfg_reg.bitmap_width   <= dim_val;
                mbbe_pkg::REG_BITMAP_HEIGHT:  cfg_reg.bitmap_height  <= dim_val;
                mbbe_pkg::REG_FORE_COLOR:     cfg_reg.fore_color     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mbbe_front #(
        .WORD_BITS (WORD_BITS),
        .MAX_DIM   (MAX_DIM),
        .WIR_W     (WIR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .bitmap_word (bitmap_word),
        .q_full      (q_full),
        .q_push      (f_push),
        .q_word      (f_word),
        .q_py        (f_py),
        .q_wir       (f_wir)
    );

    mbbe_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata ({f_word, f_py, f_wir}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    mbbe_back #(
        .WORD_BITS (WORD_BITS),
        .WIR_W     (WIR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_word       (q_rdata[Q_W-1 -: WORD_BITS]),
        .q_py         (q_rdata[WIR_W +: CW]),
        .q_wir        (q_rdata[WIR_W-1:0]),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .pixel_index  (pixel_index),
        .pixel_value  (pixel_value),
        .last_of_word (last_of_word)
    );

endmodule

/* rtl/mbbe_checker.sv */
module mbbe_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [mbbe_pkg::INDEX_W-1:0]   pixel_index,
    input logic [mbbe_pkg::VALUE_W-1:0]   pixel_value,
    input logic                           last_of_word
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_index) && $stable(last_of_word)))
        else $error("waiting result changed");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pixel_value[31:24] == mbbe_pkg::ALPHA_OPAQUE))
        else $error("alpha not opaque");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("not idle in reset");

endmodule

bind mono_bitmap_blit_expander mbbe_checker u_mbbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .pixel_index  (pixel_index),
    .pixel_value  (pixel_value),
    .last_of_word (last_of_word)
);

/* bench/mono_bitmap_blit_expander_test.sv */
`timescale 1ns / 100ps

module mono_bitmap_blit_expander_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SHOWN    = 10;
    localparam int CW           = mbbe_pkg::CFG_W;
    localparam int DW           = mbbe_pkg::CFG_DAT_W;

    typedef struct {
        logic [mbbe_pkg::INDEX_W-1:0] index;
        logic [mbbe_pkg::VALUE_W-1:0] value;
        logic                         last;
    } pixel_write_t;

    logic                           clk;
    logic                           rst_n;
    logic                           push;
    logic                           full;
    logic [31:0]                    bitmap_word;
    logic                           empty;
    logic                           pop;
    logic [mbbe_pkg::INDEX_W-1:0]   pixel_index;
    logic [mbbe_pkg::VALUE_W-1:0]   pixel_value;
    logic                           last_of_word;
    logic                           cfg_we;
    logic [mbbe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [DW-1:0]                  cfg_data;

    mono_bitmap_blit_expander dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .bitmap_word  (bitmap_word),
        .empty        (empty),
        .pop          (pop),
        .pixel_index  (pixel_index),
        .pixel_value  (pixel_value),
        .last_of_word (last_of_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // blit predictor state
    logic [CW-1:0]                  stride_q;
    logic [CW-1:0]                  vis_height_q;
    logic [CW-1:0]                  scr_width_q;
    logic signed [CW-1:0]           org_x_q;
    logic signed [CW-1:0]           org_y_q;
    logic [CW-1:0]                  bm_width_q;
    logic [CW-1:0]                  bm_height_q;
    logic [mbbe_pkg::COLOR_W-1:0]   color_q;
    logic [10:0]                    row_q;
    logic [5:0]                     word_col_q;

    pixel_write_t pending_writes[$];
    pixel_write_t want;

    int errors;
    int words_taken;
    int writes_seen;
    int reg_writes;
    int cycle_count;
    int burst_left;
    int stall_mode;
    int stall_count;
    logic holding;
    event hold_go;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v);
        return (v > 12'd2048) ? 12'd2048 : v;
    endfunction

    function automatic void load_register(input logic [mbbe_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [DW-1:0] d);
        case (idx)
            mbbe_pkg::REG_LINE_STRIDE:    stride_q     = d[CW-1:0];
            mbbe_pkg::REG_VISIBLE_HEIGHT: vis_height_q = d[CW-1:0];
            mbbe_pkg::REG_SCREEN_WIDTH:   scr_width_q  = d[CW-1:0];
            mbbe_pkg::REG_ORIGIN_X:       org_x_q      = d[CW-1:0];
            mbbe_pkg::REG_ORIGIN_Y:       org_y_q      = d[CW-1:0];
            mbbe_pkg::REG_BITMAP_WIDTH:   bm_width_q   = clamp_size(d[CW-1:0]);
            mbbe_pkg::REG_BITMAP_HEIGHT:  bm_height_q  = clamp_size(d[CW-1:0]);
            mbbe_pkg::REG_FORE_COLOR:     color_q      = d[mbbe_pkg::COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void expand_word(input logic [31:0] w);
        int           row_words;
        int           py;
        int           px;
        int           col;
        int           first;
        int           next_col;
        int           next_row;
        logic [31:0]  sum;
        pixel_write_t pw;

        if (bm_width_q == 0 || bm_height_q == 0)
        begin
            row_q      = '0;
            word_col_q = '0;
            return;
        end
        row_words = (int'(bm_width_q) + 31) / 32;
        py        = int'(org_y_q) + int'(row_q);
        first     = pending_writes.size();
        if (py >= 0 && py < int'(vis_height_q))
        begin
            for (int b = 0; b < 32; b++)
            begin
                col = int'(word_col_q) * 32 + b;
                if (col >= int'(bm_width_q))
                    break;
                if (w[31-b])
                begin
                    px = int'(org_x_q) + col;
                    if (px >= 0 && px < int'(scr_width_q))
                    begin
                        sum      = py * int'(stride_q) + px;
                        pw.index = sum[mbbe_pkg::INDEX_W-1:0];
                        pw.value = {mbbe_pkg::ALPHA_OPAQUE, color_q};
                        pw.last  = 1'b0;
                        pending_writes.push_back(pw);
                    end
                end
            end
            if (pending_writes.size() > first)
                pending_writes[pending_writes.size()-1].last = 1'b1;
        end

        next_col = int'(word_col_q) + 1;
        if (next_col >= row_words)
        begin
            word_col_q = '0;
            next_row   = int'(row_q) + 1;
            row_q      = (next_row >= int'(bm_height_q)) ? '0 : 11'(next_row);
        end
        else
        begin
            word_col_q = 6'(next_col);
        end
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            load_register(cfg_index, cfg_data);
        if (rst_n && push && !full)
        begin
            words_taken++;
            expand_word(bitmap_word);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            writes_seen++;
            if (pending_writes.size() == 0)
            begin
                note_error($sformatf("unexpected write index %h value %h last %b",
                                     pixel_index, pixel_value, last_of_word));
            end
            else
            begin
                want = pending_writes.pop_front();
                if (pixel_index !== want.index)
                    note_error($sformatf("pixel_index exp %h got %h",
                                         want.index, pixel_index));
                if (pixel_value !== want.value)
                    note_error($sformatf("pixel_value exp %h got %h",
                                         want.value, pixel_value));
                if (last_of_word !== want.last)
                    note_error($sformatf("last_of_word exp %b got %b",
                                         want.last, last_of_word));
            end
        end
    end

    always
    begin
        @(hold_go);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    always @(negedge clk)
    begin
        stall_count++;
        if (stall_count >= 100)
        begin
            stall_count = 0;
            stall_mode  = $urandom_range(0, 3);
        end
        if (holding)
            pop <= 1'b0;
        else
            case (stall_mode)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 3) != 0);
                2:       pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (stall_count % 8) < 5;
            endcase
    end

    task automatic send_word(input logic [31:0] w);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push        <= 1'b1;
        bitmap_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mbbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DW-1:0] d);
        logic [DW-1:0] data;
        data = d;
        if (idx != mbbe_pkg::REG_FORE_COLOR)
            data[DW-1:CW] = (DW - CW)'($urandom);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        reg_writes++;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // drop push, drain all expected writes, then let in-flight empty words finish
    task automatic settle();
        @(negedge clk);
        push       <= 1'b0;
        burst_left = 0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_dim(input int lo, input int hi);
        case ($urandom_range(0, 15))
            0:       return 12'h000;
            1:       return 12'hFFF;
            2:       return 12'h800;
            3:       return 12'h7FF;
            default: return CW'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic test_reset_defaults();
        repeat (4) send_word($urandom);
        settle();
        write_reg(mbbe_pkg::REG_BITMAP_WIDTH, 24'd64);
        write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, 24'd2);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0001);
        send_word(32'h0F0F_0F0F);
        send_word(32'hFFFF_FFFF);
        settle();
    endtask

    task automatic test_padding_and_negative_origin();
        write_reg(mbbe_pkg::REG_BITMAP_WIDTH, 24'd40);
        write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, 24'd3);
        write_reg(mbbe_pkg::REG_ORIGIN_X, 24'hFF8);
        write_reg(mbbe_pkg::REG_ORIGIN_Y, 24'hFFF);
        write_reg(mbbe_pkg::REG_SCREEN_WIDTH, 24'd30);
        write_reg(mbbe_pkg::REG_FORE_COLOR, 24'hFFFFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0001);
        send_word(32'hFF00_0000);
        settle();
    endtask

    task automatic test_clamp_and_index_wrap();
        write_reg(mbbe_pkg::REG_LINE_STRIDE, 24'hFFF);
        write_reg(mbbe_pkg::REG_VISIBLE_HEIGHT, 24'hFFF);
        write_reg(mbbe_pkg::REG_SCREEN_WIDTH, 24'hFFF);
        write_reg(mbbe_pkg::REG_ORIGIN_X, 24'h7FF);
        write_reg(mbbe_pkg::REG_ORIGIN_Y, 24'h7FF);
        write_reg(mbbe_pkg::REG_BITMAP_WIDTH, 24'hFFF);
        write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, 24'hFFF);
        repeat (3) send_word(32'hFFFF_FFFF);
        settle();
        // shrink the width mid-row: the next word ends the row with no writes
        write_reg(mbbe_pkg::REG_BITMAP_WIDTH, 24'd32);
        write_reg(mbbe_pkg::REG_FORE_COLOR, 24'h000000);
        send_word(32'hFFFF_FFFF);
        send_word(32'hAAAA_AAAA);
        settle();
    endtask

    task automatic test_zero_stride_and_full_clip();
        write_reg(mbbe_pkg::REG_LINE_STRIDE, 24'd0);
        write_reg(mbbe_pkg::REG_ORIGIN_X, 24'd0);
        write_reg(mbbe_pkg::REG_ORIGIN_Y, 24'd0);
        write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, 24'd1);
        write_reg(mbbe_pkg::REG_FORE_COLOR, 24'h123456);
        send_word(32'h5555_5555);
        settle();
        write_reg(mbbe_pkg::REG_SCREEN_WIDTH, 24'd0);
        send_word(32'hFFFF_FFFF);
        settle();
        write_reg(mbbe_pkg::REG_SCREEN_WIDTH, 24'd2048);
        write_reg(mbbe_pkg::REG_VISIBLE_HEIGHT, 24'd0);
        send_word(32'hFFFF_FFFF);
        settle();
        write_reg(mbbe_pkg::REG_VISIBLE_HEIGHT, 24'hFFF);
        write_reg(mbbe_pkg::REG_ORIGIN_Y, 24'h800);
        send_word(32'hFFFF_FFFF);
        settle();
        write_reg(mbbe_pkg::REG_ORIGIN_Y, 24'd0);
        write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, 24'd0);
        send_word(32'hFFFF_FFFF);
        settle();
    endtask

    task automatic test_output_backpressure();
        write_reg(mbbe_pkg::REG_LINE_STRIDE, 24'd640);
        write_reg(mbbe_pkg::REG_VISIBLE_HEIGHT, 24'd480);
        write_reg(mbbe_pkg::REG_SCREEN_WIDTH, 24'd640);
        write_reg(mbbe_pkg::REG_BITMAP_WIDTH, 24'd96);
        write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, 24'd8);
        write_reg(mbbe_pkg::REG_FORE_COLOR, 24'hA5C3E1);
        @(posedge clk);
        -> hold_go;
        burst_left = 40;
        repeat (24) send_word(($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom);
        settle();
    endtask

    task automatic test_random_blits();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(mbbe_pkg::REG_LINE_STRIDE, DW'(pick_dim(1, 2048)));
            write_reg(mbbe_pkg::REG_VISIBLE_HEIGHT, DW'(pick_dim(16, 600)));
            write_reg(mbbe_pkg::REG_SCREEN_WIDTH, DW'(pick_dim(16, 700)));
            write_reg(mbbe_pkg::REG_ORIGIN_X, DW'($urandom_range(0, 460) - 60));
            write_reg(mbbe_pkg::REG_ORIGIN_Y, ($urandom_range(0, 7) == 0)
                                              ? DW'(pick_dim(0, 0))
                                              : DW'($urandom_range(0, 310) - 10));
            write_reg(mbbe_pkg::REG_BITMAP_WIDTH, DW'(pick_dim(1, 100)));
            write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, DW'(pick_dim(1, 12)));
            write_reg(mbbe_pkg::REG_FORE_COLOR, DW'($urandom));
            repeat (30) send_word(random_word());
            settle();
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        bitmap_word  = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pop          = 1'b0;
        holding      = 1'b0;
        stall_mode   = 0;
        stall_count  = 0;
        burst_left   = 0;
        errors       = 0;
        words_taken  = 0;
        writes_seen  = 0;
        reg_writes   = 0;
        cycle_count  = 0;
        stride_q     = mbbe_pkg::RST_LINE_STRIDE;
        vis_height_q = mbbe_pkg::RST_VISIBLE_HEIGHT;
        scr_width_q  = mbbe_pkg::RST_SCREEN_WIDTH;
        org_x_q      = '0;
        org_y_q      = '0;
        bm_width_q   = '0;
        bm_height_q  = '0;
        color_q      = '0;
        row_q        = '0;
        word_col_q   = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_padding_and_negative_origin();
        test_clamp_and_index_wrap();
        test_zero_stride_and_full_clip();
        test_output_backpressure();
        test_random_blits();

        settle();
        $display("Blitted %0d bitmap words under %0d register writes; %0d pixel writes checked.",
                 words_taken, reg_writes, writes_seen);
        $display("Run covered padding, clipping, size clamping, index wrap, zero stride, %s",
                 "mid-blit resizing and a long output stall.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
